>>> rtl/stq_pkg.sv
// Shared types and codes for the sorted timer queue.
// No dependencies; imported by sorted_timer_queue.
package stq_pkg;

    typedef logic [1:0] t_cmd;
    typedef logic [2:0] t_status;

    localparam t_cmd CMD_ADD    = 2'd0;
    localparam t_cmd CMD_ADJUST = 2'd1;
    localparam t_cmd CMD_DELETE = 2'd2;
    localparam t_cmd CMD_TICK   = 2'd3;

    localparam t_status STAT_OK        = 3'd0;
    localparam t_status STAT_FULL      = 3'd1;
    localparam t_status STAT_NOT_FOUND = 3'd2;
    localparam t_status STAT_EXPIRED   = 3'd3;
    localparam t_status STAT_NONE      = 3'd4;
    localparam t_status STAT_DUPLICATE = 3'd5;

    localparam int HANDLE_W   = 16;
    localparam int TIME_W     = 32;
    localparam int ENTRY_W    = HANDLE_W + TIME_W;
    localparam int TICK_LIMIT = 16;

endpackage

>>> rtl/stq_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module stq_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/sorted_timer_queue.sv
// Sorted timer queue: entries held in expiry order in one RAM, walked by a sequencer.
// Depends on stq_pkg and stq_ram.
//
//  channel  | dir | tdata                                   | tuser        | tlast
//  s_axis   | in  | handle[15:0] expire_time[47:16] now_time[79:48] | command[1:0] | -
//  m_axis   | out | expired_handle[15:0]                    | status[2:0]  | last
//
// Add/adjust/delete: scan every live entry, shift the entries in the way, write the entry if any, post the status.
// Tick: post each expired entry, then compact the remaining entries to the front of the RAM.
// A new item is accepted only in the idle state, once the sequencer is through with the last one.
// Synchronous active-low reset empties the queue at once; the RAM needs no clearing.
// A full output register stalls the sequencer only when it has a new result to post.
module sorted_timer_queue #(
    parameter int DEPTH = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [79:0]       s_axis_tdata,   // handle, expire_time, now_time
    input  stq_pkg::t_cmd     s_axis_tuser,   // command
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [15:0]       m_axis_tdata,   // expired_handle
    output stq_pkg::t_status  m_axis_tuser,   // status
    output logic              m_axis_tlast
);

    import stq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_SRD  = 4'd1;
    localparam logic [3:0] ST_SCHK = 4'd2;
    localparam logic [3:0] ST_PLAN = 4'd3;
    localparam logic [3:0] ST_MRD  = 4'd4;
    localparam logic [3:0] ST_MWR  = 4'd5;
    localparam logic [3:0] ST_PUT  = 4'd6;
    localparam logic [3:0] ST_RES  = 4'd7;
    localparam logic [3:0] ST_TRD  = 4'd8;
    localparam logic [3:0] ST_TCHK = 4'd9;

    logic [3:0]          r_state, n_state;
    t_cmd                r_cmd, n_cmd;
    logic [HANDLE_W-1:0] r_handle, n_handle;
    logic [TIME_W-1:0]   r_exp, n_exp;
    logic [TIME_W-1:0]   r_now, n_now;
    logic [CW-1:0]       r_count, n_count;
    logic [CW-1:0]       r_idx, n_idx;
    logic                r_found, n_found;
    logic [AW-1:0]       r_fidx, n_fidx;
    logic [CW-1:0]       r_le, n_le;
    logic [AW-1:0]       r_src, n_src;
    logic [CW-1:0]       r_left, n_left;
    logic [CW-1:0]       r_dist, n_dist;
    logic                r_up, n_up;
    logic                r_put, n_put;
    t_status             r_res, n_res;
    logic                r_have, n_have;
    logic [HANDLE_W-1:0] r_pend, n_pend;
    logic                r_ovld, n_ovld;
    t_status             r_ostat, n_ostat;
    logic [HANDLE_W-1:0] r_ohnd, n_ohnd;
    logic                r_olast, n_olast;

    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [ENTRY_W-1:0]  ram_wdata;
    logic [AW-1:0]       ram_raddr;
    logic [ENTRY_W-1:0]  ram_rdata;
    logic [TIME_W-1:0]   rd_exp;
    logic [HANDLE_W-1:0] rd_hnd;
    logic                out_free;
    logic                tick_hit;
    logic [CW-1:0]       fidx_w;
    logic [CW-1:0]       cnt_m1;

    stq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_exp   = ram_rdata[TIME_W-1:0];
    assign rd_hnd   = ram_rdata[ENTRY_W-1:TIME_W];
    assign out_free = !r_ovld || m_axis_tready;
    assign fidx_w   = CW'(r_fidx);
    assign cnt_m1   = r_count - CW'(1);
    assign tick_hit = (r_idx < r_count) && (32'(r_idx) < TICK_LIMIT) && (rd_exp <= r_now);

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_ovld;
    assign m_axis_tdata  = r_ohnd;
    assign m_axis_tuser  = r_ostat;
    assign m_axis_tlast  = r_olast;

    always_comb begin
        case (r_state)
            ST_SRD, ST_SCHK, ST_TRD, ST_TCHK: ram_raddr = r_idx[AW-1:0];
            default:                          ram_raddr = r_src;
        endcase
    end

    always_comb begin
        n_state  = r_state;
        n_cmd    = r_cmd;
        n_handle = r_handle;
        n_exp    = r_exp;
        n_now    = r_now;
        n_count  = r_count;
        n_idx    = r_idx;
        n_found  = r_found;
        n_fidx   = r_fidx;
        n_le     = r_le;
        n_src    = r_src;
        n_left   = r_left;
        n_dist   = r_dist;
        n_up     = r_up;
        n_put    = r_put;
        n_res    = r_res;
        n_have   = r_have;
        n_pend   = r_pend;
        n_ovld   = r_ovld && !m_axis_tready;
        n_ostat  = r_ostat;
        n_ohnd   = r_ohnd;
        n_olast  = r_olast;
        ram_we    = 1'b0;
        ram_waddr = r_le[AW-1:0];
        ram_wdata = {r_handle, r_exp};

        case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_cmd    = s_axis_tuser;
                    n_handle = s_axis_tdata[15:0];
                    n_exp    = s_axis_tdata[47:16];
                    n_now    = s_axis_tdata[79:48];
                    n_idx    = '0;
                    n_found  = 1'b0;
                    n_le     = '0;
                    n_have   = 1'b0;
                    n_state  = (s_axis_tuser == CMD_TICK) ? ST_TRD : ST_SRD;
                end
            end
            ST_SRD: begin
                n_state = (r_idx == r_count) ? ST_PLAN : ST_SCHK;
            end
            ST_SCHK: begin
                if (rd_hnd == r_handle) begin
                    n_found = 1'b1;
                    n_fidx  = r_idx[AW-1:0];
                end else if (rd_exp <= r_exp) begin
                    n_le = r_le + CW'(1);
                end
                n_idx   = r_idx + CW'(1);
                n_state = ST_SRD;
            end
            ST_PLAN: begin
                n_res   = STAT_OK;
                n_state = ST_MRD;
                case (r_cmd)
                    CMD_ADD: begin
                        if (r_found) begin
                            n_res   = STAT_DUPLICATE;
                            n_state = ST_RES;
                        end else if (r_count == CW'(DEPTH)) begin
                            n_res   = STAT_FULL;
                            n_state = ST_RES;
                        end else begin
                            n_up    = 1'b1;
                            n_src   = cnt_m1[AW-1:0];
                            n_left  = r_count - r_le;
                            n_put   = 1'b1;
                            n_count = r_count + CW'(1);
                        end
                    end
                    CMD_DELETE: begin
                        if (!r_found) begin
                            n_res   = STAT_NOT_FOUND;
                            n_state = ST_RES;
                        end else begin
                            n_up    = 1'b0;
                            n_dist  = CW'(1);
                            n_src   = r_fidx + AW'(1);
                            n_left  = cnt_m1 - fidx_w;
                            n_put   = 1'b0;
                            n_count = cnt_m1;
                        end
                    end
                    CMD_ADJUST: begin
                        n_put = 1'b1;
                        if (!r_found) begin
                            n_res   = STAT_NOT_FOUND;
                            n_state = ST_RES;
                        end else if (r_le >= fidx_w) begin
                            n_up   = 1'b0;
                            n_dist = CW'(1);
                            n_src  = r_fidx + AW'(1);
                            n_left = r_le - fidx_w;
                        end else begin
                            n_up   = 1'b1;
                            n_src  = r_fidx - AW'(1);
                            n_left = fidx_w - r_le;
                        end
                    end
                    default: begin
                        n_state = ST_IDLE;
                    end
                endcase
            end
            ST_MRD: begin
                if (r_left != '0) begin
                    n_state = ST_MWR;
                end else if (r_put) begin
                    n_state = ST_PUT;
                end else if (r_cmd == CMD_TICK) begin
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_RES;
                end
            end
            ST_MWR: begin
                ram_we    = 1'b1;
                ram_waddr = r_up ? (r_src + AW'(1)) : (r_src - r_dist[AW-1:0]);
                ram_wdata = ram_rdata;
                n_src     = r_up ? (r_src - AW'(1)) : (r_src + AW'(1));
                n_left    = r_left - CW'(1);
                n_state   = ST_MRD;
            end
            ST_PUT: begin
                ram_we  = 1'b1;
                n_state = ST_RES;
            end
            ST_RES: begin
                if (out_free) begin
                    n_ovld  = 1'b1;
                    n_ostat = r_res;
                    n_ohnd  = '0;
                    n_olast = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            ST_TRD: begin
                n_state = ST_TCHK;
            end
            ST_TCHK: begin
                // the held handle goes out once the next entry shows whether it is last
                if (out_free || (tick_hit && !r_have)) begin
                    if (r_have) begin
                        n_ovld  = 1'b1;
                        n_ostat = STAT_EXPIRED;
                        n_ohnd  = r_pend;
                        n_olast = !tick_hit;
                    end else if (!tick_hit) begin
                        n_ovld  = 1'b1;
                        n_ostat = STAT_NONE;
                        n_ohnd  = '0;
                        n_olast = 1'b1;
                    end
                    if (tick_hit) begin
                        n_pend  = rd_hnd;
                        n_have  = 1'b1;
                        n_idx   = r_idx + CW'(1);
                        n_state = ST_TRD;
                    end else begin
                        n_up    = 1'b0;
                        n_dist  = r_idx;
                        n_src   = r_idx[AW-1:0];
                        n_left  = r_count - r_idx;
                        n_put   = 1'b0;
                        n_count = r_count - r_idx;
                        n_state = ST_MRD;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_ovld  <= 1'b0;
            r_have  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ovld  <= n_ovld;
            r_have  <= n_have;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_handle <= n_handle;
        r_exp    <= n_exp;
        r_now    <= n_now;
        r_idx    <= n_idx;
        r_found  <= n_found;
        r_fidx   <= n_fidx;
        r_le     <= n_le;
        r_src    <= n_src;
        r_left   <= n_left;
        r_dist   <= n_dist;
        r_up     <= n_up;
        r_put    <= n_put;
        r_res    <= n_res;
        r_pend   <= n_pend;
        r_ostat  <= n_ostat;
        r_ohnd   <= n_ohnd;
        r_olast  <= n_olast;
    end

endmodule

>>> bench/sorted_timer_queue_test.sv
// Self-checking bench for sorted_timer_queue: directed and random add/adjust/delete/tick items.
// A scoreboard class keeps its own sorted timer list and checks every result item.
// Depends on stq_pkg and the sorted_timer_queue RTL.

localparam int QUEUE_DEPTH = 16;

typedef struct packed {
    stq_pkg::t_status status;
    logic [15:0]      handle;
    logic             last;
} t_timer_report;

class timer_scoreboard;
    logic [31:0]   live_expiry[$];
    logic [15:0]   live_handle[$];
    t_timer_report pending_reports[$];
    int            errors = 0;

    function int find_handle(logic [15:0] h);
        foreach (live_handle[i])
            if (live_handle[i] == h) return i;
        return -1;
    endfunction

    function void insert_timer(logic [15:0] h, logic [31:0] e);
        int pos;
        pos = 0;
        while (pos < live_expiry.size() && live_expiry[pos] <= e) pos++;
        live_expiry.insert(pos, e);
        live_handle.insert(pos, h);
    endfunction

    function void post(stq_pkg::t_status st, logic [15:0] h, logic l);
        t_timer_report r;
        r.status = st;
        r.handle = h;
        r.last   = l;
        pending_reports.push_back(r);
    endfunction

    // predicts the result items of one accepted command
    function void apply_command(stq_pkg::t_cmd c, logic [15:0] h, logic [31:0] e,
                                logic [31:0] now);
        int idx;
        int n;
        if (c == stq_pkg::CMD_TICK) begin
            n = 0;
            while (n < live_expiry.size() && n < stq_pkg::TICK_LIMIT && live_expiry[n] <= now)
                n++;
            if (n == 0) begin
                post(stq_pkg::STAT_NONE, 16'h0, 1'b1);
                return;
            end
            for (int k = 0; k < n; k++) begin
                post(stq_pkg::STAT_EXPIRED, live_handle[0], k == n - 1);
                void'(live_expiry.pop_front());
                void'(live_handle.pop_front());
            end
            return;
        end
        idx = find_handle(h);
        if (c == stq_pkg::CMD_ADD) begin
            if (idx >= 0) begin
                post(stq_pkg::STAT_DUPLICATE, 16'h0, 1'b1);
            end else if (live_expiry.size() >= QUEUE_DEPTH) begin
                post(stq_pkg::STAT_FULL, 16'h0, 1'b1);
            end else begin
                insert_timer(h, e);
                post(stq_pkg::STAT_OK, 16'h0, 1'b1);
            end
            return;
        end
        if (idx < 0) begin
            post(stq_pkg::STAT_NOT_FOUND, 16'h0, 1'b1);
            return;
        end
        live_expiry.delete(idx);
        live_handle.delete(idx);
        if (c == stq_pkg::CMD_ADJUST) insert_timer(h, e);
        post(stq_pkg::STAT_OK, 16'h0, 1'b1);
    endfunction

    function void check_result(stq_pkg::t_status st, logic [15:0] h, logic l);
        t_timer_report want;
        if (pending_reports.size() == 0) begin
            $error("unexpected result item: status %0d handle %h last %0d", st, h, l);
            errors++;
            return;
        end
        want = pending_reports.pop_front();
        if (st !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, st);
            errors++;
        end
        if (h !== want.handle) begin
            $error("expired_handle: expected %h, got %h", want.handle, h);
            errors++;
        end
        if (l !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, l);
            errors++;
        end
    endfunction

    function int pending();
        return pending_reports.size();
    endfunction

    function int live_count();
        return live_handle.size();
    endfunction

    function logic [15:0] pick_live_handle();
        return live_handle[$urandom_range(live_handle.size() - 1)];
    endfunction
endclass

module sorted_timer_queue_test;
    timeunit 1ns;
    timeprecision 1ps;

    import stq_pkg::*;

    localparam int RANDOM_ITEMS = 200;
    localparam int STALL_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 4 * QUEUE_DEPTH + 20;

    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata  = '0;     // handle, expire_time, now_time
    t_cmd        s_axis_tuser  = CMD_TICK; // command
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;           // expired_handle
    t_status     m_axis_tuser;           // status
    logic        m_axis_tlast;

    bit              calm = 1'b0;
    timer_scoreboard board;

    sorted_timer_queue #(.DEPTH(QUEUE_DEPTH)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic send_command(t_cmd c, logic [15:0] h, logic [31:0] e, logic [31:0] now);
        while (!calm && $urandom_range(99) < 7) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {now, e, h};
        s_axis_tuser  <= c;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        board.apply_command(c, h, e, now);
    endtask

    task automatic send_random(logic [31:0] base);
        int          pick;
        t_cmd        c;
        logic [15:0] h;
        logic [31:0] e;
        logic [31:0] now;
        pick = $urandom_range(99);
        c = pick < 35 ? CMD_ADD : pick < 55 ? CMD_ADJUST : pick < 70 ? CMD_DELETE : CMD_TICK;
        h = 16'($urandom_range(16'hFFFF));
        e = $urandom_range(99) < 85 ? base + $urandom_range(60) : $urandom;
        pick = $urandom_range(99);
        now = pick < 80 ? base + $urandom_range(60) : pick < 90 ? $urandom :
              pick < 95 ? 32'h0 : 32'hFFFF_FFFF;
        if (board.live_count() > 0) begin
            if (c == CMD_ADD && $urandom_range(99) < 25) h = board.pick_live_handle();
            if ((c == CMD_ADJUST || c == CMD_DELETE) && $urandom_range(99) < 80)
                h = board.pick_live_handle();
        end
        send_command(c, h, e, now);
    endtask

    // result side: check on handshake, then pick tready for the next edge
    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready)
                board.check_result(m_axis_tuser, m_axis_tdata, m_axis_tlast);
            m_axis_tready <= calm || $urandom_range(99) >= 7;
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin : stimulus
        logic [15:0] h;
        logic [31:0] e;
        logic [31:0] base;
        board = new();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty store: tick with nothing, unknown handles
        send_command(CMD_TICK, 16'h0, 32'h0, 32'hFFFF_FFFF);
        send_command(CMD_ADJUST, 16'h0001, 32'h10, 32'h0);
        send_command(CMD_DELETE, 16'hFFFF, 32'hFFFF_FFFF, 32'h0);
        // fill the store; several equal expiries keep arrival order
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            h = i == 0 ? 16'h0 : i == 1 ? 16'hFFFF : 16'(16'h5A00 + i);
            e = i == 0 ? 32'hFFFF_FFFF : i == 1 ? 32'h0 : (i % 3 != 0) ? 32'd100 : 32'd50 + i;
            send_command(CMD_ADD, h, e, 32'h0);
        end
        send_command(CMD_ADD, 16'h7777, 32'd5, 32'h0);
        // duplicate wins over full
        send_command(CMD_ADD, 16'h0, 32'd5, 32'h0);
        send_command(CMD_ADJUST, 16'h0, 32'h0, 32'h0);
        send_command(CMD_ADJUST, 16'hFFFF, 32'd100, 32'h0);
        send_command(CMD_DELETE, 16'h5A02, 32'h0, 32'h0);
        send_command(CMD_TICK, 16'h0, 32'h0, 32'h0);
        send_command(CMD_TICK, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

        base = $urandom;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            calm = n >= 80 && n < 140;
            send_random(base);
            base = base + $urandom_range(8);
        end
        calm = 1'b0;
        s_axis_tvalid <= 1'b0;

        while (board.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (board.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
